// ===== hdl/sfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span future score package
// Shared widths, command codes and payload structs of the span scorer.
// ----------------------------------------------------------------------------
package sfs_pkg;

	// Sizes of the sentence and of the option store.
	localparam int MAX_WORDS   = 64;
	localparam int MAX_OPTIONS = 256;

	// Derived widths.
	localparam int WORD_W   = $clog2(MAX_WORDS);
	localparam int LEN_W    = $clog2(MAX_WORDS + 1);
	localparam int OPT_AW   = $clog2(MAX_OPTIONS);
	localparam int CNT_W    = $clog2(MAX_OPTIONS + 1);
	localparam int DP_DEPTH = MAX_WORDS + 1;
	localparam int DP_AW    = $clog2(DP_DEPTH);
	localparam int SCORE_W  = 32;

	// Command codes.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [WORD_W-1:0]         first_word;
		logic [WORD_W-1:0]         last_word;
		logic signed [SCORE_W-1:0] option_score;
	} sfs_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]         span_start;
		logic [WORD_W-1:0]         span_end;
		logic signed [SCORE_W-1:0] best_score;
		logic                      reachable;
		logic                      store_full;
	} sfs_rsp_t;

	// One stored span option.
	typedef struct packed {
		logic [WORD_W-1:0]         start;
		logic [LEN_W-1:0]          length;
		logic signed [SCORE_W-1:0] score;
	} sfs_opt_t;

endpackage

// ===== hdl/sfs_opt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Option store
// Single write port, single registered read port memory of span options.
// ----------------------------------------------------------------------------
module sfs_opt_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [sfs_pkg::OPT_AW-1:0] wr_addr,
	input  sfs_pkg::sfs_opt_t         wr_data,
	input  logic                      rd_en,
	input  logic [sfs_pkg::OPT_AW-1:0] rd_addr,
	output sfs_pkg::sfs_opt_t         rd_data
);
	import sfs_pkg::*;

	sfs_opt_t mem [MAX_OPTIONS];
	sfs_opt_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/sfs_dp_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DP score memory
// Per-offset best scores of the running query, registered read port.
// ----------------------------------------------------------------------------
module sfs_dp_mem (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [sfs_pkg::DP_AW-1:0]         wr_addr,
	input  logic signed [sfs_pkg::SCORE_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [sfs_pkg::DP_AW-1:0]         rd_addr,
	output logic signed [sfs_pkg::SCORE_W-1:0] rd_data
);
	import sfs_pkg::*;

	logic signed [SCORE_W-1:0] mem [DP_DEPTH];
	logic signed [SCORE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/sfs_score_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Score add and compare unit
// Saturating add of two scores and a strict compare against the held best.
// ----------------------------------------------------------------------------
module sfs_score_alu (
	input  logic signed [sfs_pkg::SCORE_W-1:0] opt_score,
	input  logic signed [sfs_pkg::SCORE_W-1:0] base_score,
	input  logic signed [sfs_pkg::SCORE_W-1:0] held_score,
	input  logic                              held_valid,
	output logic signed [sfs_pkg::SCORE_W-1:0] cand_score,
	output logic                              take
);
	import sfs_pkg::*;

	logic signed [SCORE_W:0] sum_wide;

	always_comb begin
		sum_wide = {opt_score[SCORE_W-1], opt_score} + {base_score[SCORE_W-1], base_score};
		// A carry into the extra sign bit that disagrees with the top bit means overflow.
		if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1]) begin
			cand_score = sum_wide[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
			                               : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			cand_score = sum_wide[SCORE_W-1:0];
		end
		take = !held_valid || (cand_score > held_score);
	end

endmodule

// ===== hdl/span_future_score_dp.sv =====
// Clear and load requests are taken in the idle state, and ready stays high for the next one.
// A query holds ready low while the sequencer walks the span offsets and, for every reachable
// offset, scans each stored option and updates the end offset of each matching option.
// The scan of the option store, one read at a time, sets how long this takes. A broken span
// skips the scan, and an earlier response that is still unclaimed holds the block in ST_DONE.
// Reset clears the sequencer, the option count, the overflow flag and response valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span future score DP
// Stores scored span options and answers span queries with a max-sum DP.
// ----------------------------------------------------------------------------
module span_future_score_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sfs_pkg::sfs_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sfs_pkg::sfs_rsp_t rsp
);
	import sfs_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,  // waiting for a request
		ST_CUR  = 7'b0000010,  // pick the next span offset
		ST_LOAD = 7'b0000100,  // latch the score of the current offset
		ST_SCAN = 7'b0001000,  // test one stored option against the offset
		ST_UPD  = 7'b0010000,  // add, compare and write back the end offset
		ST_FIN  = 7'b0100000,  // read out the score at the span end
		ST_DONE = 7'b1000000   // hand the result to the response register
	} state_t;

	state_t state_q;

	// Query context.
	logic [WORD_W-1:0]         first_q;
	logic [WORD_W-1:0]         last_q;
	logic [LEN_W-1:0]          len_q;
	logic [LEN_W-1:0]          cur_q;
	logic [CNT_W-1:0]          k_q;
	logic [DP_AW-1:0]          idx_q;
	logic signed [SCORE_W-1:0] cur_score_q;
	logic [DP_DEPTH-1:0]       dp_valid_q;

	// Store bookkeeping.
	logic [CNT_W-1:0] opt_count_q;
	logic             ovf_q;

	// Result of the query before it enters the response register.
	logic signed [SCORE_W-1:0] res_score_q;
	logic                      res_reach_q;

	sfs_rsp_t rsp_q;
	logic     rsp_valid_q;

	// Memory and unit hookup.
	logic                      opt_wr_en;
	sfs_opt_t                  opt_wr_data;
	logic                      opt_rd_en;
	logic [OPT_AW-1:0]         opt_rd_addr;
	sfs_opt_t                  opt_rd;
	logic                      dp_rd_en;
	logic [DP_AW-1:0]          dp_rd_addr;
	logic signed [SCORE_W-1:0] dp_rd;
	logic signed [SCORE_W-1:0] cand_score;
	logic                      take;

	// Request decode.
	logic                req_fire;
	logic                req_span_ok;
	logic                store_has_room;
	logic [LEN_W-1:0]    req_len;

	// Option match in the scan state.
	logic [LEN_W-1:0]    want_start;
	logic [LEN_W:0]      end_sum;
	logic                opt_hit;
	logic                last_opt;
	logic                rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;

	// A span is usable when it is ordered and lies inside the sentence.
	assign req_span_ok = (req.first_word <= req.last_word) &&
	                     ({1'b0, req.last_word} < LEN_W'(MAX_WORDS));
	assign req_len = {1'b0, req.last_word} - {1'b0, req.first_word} + LEN_W'(1);
	assign store_has_room = (opt_count_q < CNT_W'(MAX_OPTIONS));

	// An option extends the current offset when it starts on it and ends
	// inside the span. Stored lengths are never zero.
	assign want_start = {1'b0, first_q} + cur_q;
	assign end_sum    = {1'b0, cur_q} + {1'b0, opt_rd.length};
	assign opt_hit    = ({1'b0, opt_rd.start} == want_start) && (end_sum <= {1'b0, len_q});
	assign last_opt   = ((k_q + CNT_W'(1)) == opt_count_q);

	assign rsp_free = !rsp_valid_q || rsp_ready;

	// Loads go straight into the store at the request.
	assign opt_wr_en = req_fire && (req.cmd == CMD_LOAD) && req_span_ok && store_has_room;
	always_comb begin
		opt_wr_data.start  = req.first_word;
		opt_wr_data.length = req_len;
		opt_wr_data.score  = req.option_score;
	end

	// Read port scheduling. The store is read at entry zero when an offset
	// opens and at the next entry after each option is finished.
	always_comb begin
		opt_rd_en   = 1'b0;
		opt_rd_addr = k_q[OPT_AW-1:0];
		dp_rd_en    = 1'b0;
		dp_rd_addr  = cur_q[DP_AW-1:0];
		case (state_q)
			ST_CUR: begin
				if (cur_q == len_q) begin
					dp_rd_en   = 1'b1;
					dp_rd_addr = len_q[DP_AW-1:0];
				end else if (dp_valid_q[cur_q[DP_AW-1:0]] && (opt_count_q != '0)) begin
					dp_rd_en    = 1'b1;
					opt_rd_en   = 1'b1;
					opt_rd_addr = '0;
				end
			end
			ST_SCAN: begin
				if (opt_hit) begin
					dp_rd_en   = 1'b1;
					dp_rd_addr = end_sum[DP_AW-1:0];
				end else if (!last_opt) begin
					opt_rd_en   = 1'b1;
					opt_rd_addr = OPT_AW'(k_q + CNT_W'(1));
				end
			end
			ST_UPD: begin
				if (!last_opt) begin
					opt_rd_en   = 1'b1;
					opt_rd_addr = OPT_AW'(k_q + CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	sfs_opt_store u_opt_store (
		.clk     (clk),
		.wr_en   (opt_wr_en),
		.wr_addr (opt_count_q[OPT_AW-1:0]),
		.wr_data (opt_wr_data),
		.rd_en   (opt_rd_en),
		.rd_addr (opt_rd_addr),
		.rd_data (opt_rd)
	);

	sfs_dp_mem u_dp_mem (
		.clk     (clk),
		.wr_en   ((state_q == ST_UPD) && take),
		.wr_addr (idx_q),
		.wr_data (cand_score),
		.rd_en   (dp_rd_en),
		.rd_addr (dp_rd_addr),
		.rd_data (dp_rd)
	);

	// The one adder and comparator, reused for every matching option.
	sfs_score_alu u_alu (
		.opt_score  (opt_rd.score),
		.base_score (cur_score_q),
		.held_score (dp_rd),
		.held_valid (dp_valid_q[idx_q]),
		.cand_score (cand_score),
		.take       (take)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			opt_count_q <= '0;
			ovf_q       <= 1'b0;
			dp_valid_q  <= '0;
			cur_q       <= '0;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new response may replace one that is claimed in the same cycle.
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.cmd)
							CMD_CLEAR: begin
								opt_count_q <= '0;
								ovf_q       <= 1'b0;
							end
							CMD_LOAD: begin
								if (req_span_ok) begin
									if (store_has_room) begin
										opt_count_q <= opt_count_q + CNT_W'(1);
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							CMD_QUERY: begin
								// Offset zero is reachable with score zero.
								dp_valid_q <= DP_DEPTH'(1);
								cur_q      <= '0;
								state_q    <= req_span_ok ? ST_CUR : ST_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CUR: begin
					if (cur_q == len_q) begin
						state_q <= ST_FIN;
					end else if (dp_valid_q[cur_q[DP_AW-1:0]] && (opt_count_q != '0)) begin
						k_q     <= '0;
						state_q <= ST_LOAD;
					end else begin
						cur_q <= cur_q + LEN_W'(1);
					end
				end
				ST_LOAD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (opt_hit) begin
						state_q <= ST_UPD;
					end else if (last_opt) begin
						cur_q   <= cur_q + LEN_W'(1);
						state_q <= ST_CUR;
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				ST_UPD: begin
					if (take) begin
						dp_valid_q[idx_q] <= 1'b1;
					end
					if (last_opt) begin
						cur_q   <= cur_q + LEN_W'(1);
						state_q <= ST_CUR;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Wait here only while an earlier response is still unclaimed.
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query payload registers.
	always_ff @(posedge clk) begin
		if (req_fire && (req.cmd == CMD_QUERY)) begin
			first_q     <= req.first_word;
			last_q      <= req.last_word;
			len_q       <= req_len;
			res_score_q <= '0;
			res_reach_q <= 1'b0;
		end
		if (state_q == ST_LOAD) begin
			// At offset zero the memory read is ignored; its score is zero.
			cur_score_q <= (cur_q == '0) ? '0 : dp_rd;
		end
		if ((state_q == ST_SCAN) && opt_hit) begin
			idx_q <= end_sum[DP_AW-1:0];
		end
		if (state_q == ST_FIN) begin
			res_reach_q <= dp_valid_q[len_q[DP_AW-1:0]];
			res_score_q <= dp_valid_q[len_q[DP_AW-1:0]] ? dp_rd : '0;
		end
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q.span_start <= first_q;
			rsp_q.span_end   <= last_q;
			rsp_q.best_score <= res_score_q;
			rsp_q.reachable  <= res_reach_q;
			rsp_q.store_full <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/span_future_score_dp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span future score DP testbench
// Drives clear, load and query requests into the span scorer with random
// stalls on both channels. A local max-sum segmentation predictor computes
// every query response, and a monitor checks each response field by field
// in order.
// ----------------------------------------------------------------------------
module span_future_score_dp_tb;

	import sfs_pkg::*;

	// Code three is not a command. The block drops it and sends no response.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fffffff;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh80000000;

	// A query costs at most one scan of the stored options per span offset. With
	// only about a hundred requests in the run, this limit stays several times
	// above any correct run even with both sides stalling.
	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 50;

	// Inside this window of cycles neither side idles.
	localparam int QUIET_FROM = 2000;
	localparam int QUIET_TO   = 6000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	sfs_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	sfs_rsp_t rsp;

	span_future_score_dp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Requests waiting to be driven, and responses that queries have earned
	// but that have not yet come back.
	sfs_req_t req_plan[$];
	sfs_rsp_t pending_rsps[$];

	int sent_count = 0;
	int taken_count = 0;
	int cycle_count = 0;
	int err_count = 0;

	// Predictor copy of the option store.
	logic [WORD_W-1:0]         store_start [MAX_OPTIONS];
	logic [LEN_W-1:0]          store_len   [MAX_OPTIONS];
	logic signed [SCORE_W-1:0] store_score [MAX_OPTIONS];
	int                        store_count = 0;
	bit                        store_overflow = 1'b0;

	function automatic logic signed [SCORE_W-1:0] score_sat_add(
		input logic signed [SCORE_W-1:0] a,
		input logic signed [SCORE_W-1:0] b
	);
		logic signed [SCORE_W:0] sum;
		sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
		// The two top bits differ only when the sum left the 32-bit range.
		if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			return sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
		end
		return sum[SCORE_W-1:0];
	endfunction

	// Best segmentation of the span [first, last] by the stored options.
	// Offsets are walked in rising order and the options in load order; a
	// candidate only replaces a reachable offset when it is strictly greater.
	function automatic sfs_rsp_t span_best_score(input sfs_req_t r);
		logic signed [SCORE_W-1:0] dp_sc [DP_DEPTH];
		bit                        dp_ok [DP_DEPTH];
		logic signed [SCORE_W-1:0] cand;
		sfs_rsp_t                  res;
		int                        span_len;
		int                        cur;
		int                        k;
		int                        idx;
		res = '0;
		res.span_start = r.first_word;
		res.span_end = r.last_word;
		res.store_full = store_overflow;
		if (r.first_word <= r.last_word) begin
			span_len = int'(r.last_word) - int'(r.first_word) + 1;
			for (k = 0; k < DP_DEPTH; k++) begin
				dp_ok[k] = 1'b0;
				dp_sc[k] = '0;
			end
			dp_ok[0] = 1'b1;
			for (cur = 0; cur < span_len; cur++) begin
				if (dp_ok[cur]) begin
					for (k = 0; k < store_count; k++) begin
						idx = cur + int'(store_len[k]);
						if (int'(store_start[k]) == cur + int'(r.first_word) &&
						    idx <= span_len) begin
							cand = score_sat_add(store_score[k], dp_sc[cur]);
							if (!dp_ok[idx] || cand > dp_sc[idx]) begin
								dp_sc[idx] = cand;
								dp_ok[idx] = 1'b1;
							end
						end
					end
				end
			end
			res.reachable = dp_ok[span_len];
			res.best_score = dp_ok[span_len] ? dp_sc[span_len] : '0;
		end
		return res;
	endfunction

	// Applies one accepted request to the predictor. Only a query earns a
	// response.
	task automatic take_request(input sfs_req_t r);
		case (r.cmd)
			CMD_CLEAR: begin
				store_count = 0;
				store_overflow = 1'b0;
			end
			CMD_LOAD: begin
				// An option running backwards is dropped without a flag.
				if (r.last_word >= r.first_word) begin
					if (store_count >= MAX_OPTIONS) begin
						store_overflow = 1'b1;
					end else begin
						store_start[store_count] = r.first_word;
						store_len[store_count] = LEN_W'(r.last_word - r.first_word + 1);
						store_score[store_count] = r.option_score;
						store_count++;
					end
				end
			end
			CMD_QUERY: begin
				pending_rsps = {pending_rsps, span_best_score(r)};
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic signed [SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 5))
			0: return SCORE_MAX;
			1: return SCORE_MIN;
			2: return $urandom();
			// Small values in Q16.16, both signs.
			3: return (int'($urandom_range(0, 2000)) - 1000) <<< 8;
			4: return 32'sh40000000 + $urandom_range(0, 32'h3fffffff);
			default: return SCORE_MIN + $urandom_range(0, 32'h3fffffff);
		endcase
	endfunction

	task automatic plan_req(
		input logic [1:0]                cmd,
		input int                        first,
		input int                        last,
		input logic signed [SCORE_W-1:0] score
	);
		sfs_req_t r;
		r.cmd = cmd;
		r.first_word = WORD_W'(first);
		r.last_word = WORD_W'(last);
		r.option_score = score;
		req_plan = {req_plan, r};
	endtask

	// Sometimes clears the store, then loads a chain of options that tiles [first, last]
	// and a few overlapping alternatives, and queries the span, maybe a piece of it and maybe a random span.
	task automatic plan_tiled_span(output int planned);
		int first;
		int last;
		int pos;
		int seg;
		int n;
		int s;
		planned = 0;
		first = $urandom_range(0, MAX_WORDS - 1);
		if ($urandom_range(0, 9) == 0) begin
			last = $urandom_range(first, MAX_WORDS - 1);
		end else begin
			last = $urandom_range(first, (first + 7 < MAX_WORDS) ? first + 7 : MAX_WORDS - 1);
		end
		if ($urandom_range(0, 1) == 0) begin
			plan_req(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
			planned++;
		end
		pos = first;
		while (pos <= last) begin
			seg = $urandom_range(1, (last - pos + 1 < 4) ? last - pos + 1 : 4);
			plan_req(CMD_LOAD, pos, pos + seg - 1, pick_score());
			planned++;
			pos += seg;
		end
		n = $urandom_range(0, 4);
		repeat (n) begin
			s = $urandom_range(first, last);
			plan_req(CMD_LOAD, s, $urandom_range(s, last), pick_score());
			planned++;
		end
		plan_req(CMD_QUERY, first, last, $urandom());
		planned++;
		if ($urandom_range(0, 1) == 0) begin
			s = $urandom_range(first, last);
			plan_req(CMD_QUERY, s, $urandom_range(s, last), $urandom());
			planned++;
		end
		if ($urandom_range(0, 2) == 0) begin
			plan_req(CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
			planned++;
		end
	endtask

	task automatic report_diff(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			err_count++;
		end
	endtask

	function automatic bit quiet_window();
		return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
	endfunction

	// Sampling side. Requests and responses are taken at the rising edge, while
	// the driven signals only move at the falling edge, so nothing races.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && req_valid && req_ready) begin
			take_request(req);
			taken_count <= taken_count + 1;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t ns: response with none expected, actual %p", $time, rsp);
				err_count++;
			end else begin
				report_diff("span_start", pending_rsps[0].span_start, rsp.span_start);
				report_diff("span_end", pending_rsps[0].span_end, rsp.span_end);
				report_diff("best_score", pending_rsps[0].best_score, rsp.best_score);
				report_diff("reachable", pending_rsps[0].reachable, rsp.reachable);
				report_diff("store_full", pending_rsps[0].store_full, rsp.store_full);
				void'(pending_rsps.pop_front());
			end
		end
	end

	// Request driver. A new request goes out only once the previous one has
	// been taken; valid then stays high with the payload held until accepted.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || sent_count == taken_count) begin
			if (req_plan.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 33)) begin
				req <= req_plan.pop_front();
				req_valid <= 1'b1;
				sent_count <= sent_count + 1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure.
	always @(negedge clk) begin
		rsp_ready <= quiet_window() || $urandom_range(0, 99) >= 33;
	end

	initial begin
		int planned;
		int rand_items;

		// Directed part.
		plan_req(CMD_QUERY, 0, 0, '0);                 // empty store, unreachable
		plan_req(CMD_UNUSED, 63, 63, 32'shffffffff);   // ignored command
		plan_req(CMD_LOAD, 0, 0, SCORE_MAX);
		plan_req(CMD_LOAD, 1, 1, SCORE_MAX);
		plan_req(CMD_QUERY, 0, 1, '0);                 // sum saturates high
		plan_req(CMD_LOAD, 0, 63, SCORE_MIN);          // whole sentence at once
		plan_req(CMD_LOAD, 63, 63, -32'sd1);
		plan_req(CMD_QUERY, 0, 63, '0);
		plan_req(CMD_QUERY, 63, 63, '0);
		plan_req(CMD_LOAD, 10, 5, 32'sh00010000);      // backwards option, dropped
		plan_req(CMD_QUERY, 5, 10, '0);
		plan_req(CMD_QUERY, 10, 5, '0);                // backwards span
		plan_req(CMD_LOAD, 3, 3, SCORE_MIN);
		plan_req(CMD_LOAD, 4, 4, SCORE_MIN);
		plan_req(CMD_QUERY, 3, 4, '0);                 // sum saturates low
		plan_req(CMD_LOAD, 2, 3, 32'sh00050000);       // tie with an equal path
		plan_req(CMD_LOAD, 2, 2, 32'sh00020000);
		plan_req(CMD_LOAD, 3, 3, 32'sh00030000);
		plan_req(CMD_QUERY, 2, 3, '0);
		plan_req(CMD_CLEAR, 63, 0, SCORE_MAX);
		plan_req(CMD_QUERY, 0, 63, '0);                // cleared store
		plan_req(CMD_QUERY, 0, 1, SCORE_MIN);

		// Random part: mostly well-formed spans, plus noise and broken
		// requests.
		rand_items = 0;
		while (rand_items < 80) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					plan_req(2'($urandom_range(0, 3)), $urandom_range(0, 63),
					         $urandom_range(0, 63), $urandom());
					rand_items++;
				end
				2: begin
					planned = $urandom_range(1, 62);
					plan_req($urandom_range(0, 1) ? CMD_LOAD : CMD_QUERY, planned,
					         $urandom_range(0, planned - 1), $urandom());
					rand_items++;
				end
				default: begin
					plan_tiled_span(planned);
					rand_items += planned;
				end
			endcase
		end

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_plan.size() != 0 || sent_count != taken_count || pending_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/sfs_pkg.sv
hdl/sfs_opt_store.sv
hdl/sfs_dp_mem.sv
hdl/sfs_score_alu.sv
hdl/span_future_score_dp.sv
verif/span_future_score_dp_tb.sv
